>>> rtl/core/afk_pkg.sv
package afk_pkg;

	localparam int AFK_ANGLE_BITS = 16;
	localparam int AFK_FRAC_BITS  = 16;

	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int TRIG_W       = 32;
	localparam int TRIG_FRAC    = 30;
	localparam int CX_W         = 34;
	localparam int CZ_W         = 33;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOREARM_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRIST_LENGTH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_OFFSET      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WRIST_DROP       = 3'd5;

	typedef logic signed [TRIG_W-1:0] trig_t;

	// atan(2^-i) in 2^32 per turn
	function automatic logic [31:0] atan_val(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/afk_if.sv
interface afk_in_if #(parameter int ANGLE_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] base_angle;
	logic [ANGLE_BITS-1:0] shoulder_angle;
	logic [ANGLE_BITS-1:0] elbow_angle;
	logic [ANGLE_BITS-1:0] wrist_pitch_angle;
	logic [ANGLE_BITS-1:0] wrist_roll_angle;

	modport source (output valid, base_angle, shoulder_angle, elbow_angle,
		wrist_pitch_angle, wrist_roll_angle, input ready);
	modport sink (input valid, base_angle, shoulder_angle, elbow_angle,
		wrist_pitch_angle, wrist_roll_angle, output ready);
endinterface

interface afk_out_if #(parameter int OUT_BITS = 23);
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] pos_x;
	logic signed [OUT_BITS-1:0] pos_y;
	logic signed [OUT_BITS-1:0] pos_z;

	modport source (output valid, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

>>> rtl/core/arm_forward_kinematics_5dof_top.sv
// pipeline: 32 cordic stages and 8 transform stages from request to result
// throughput: one request per cycle, the whole pipeline holds when the result is not taken
// reset: clears all valid bits and loads the default link lengths
// link registers are read live, so write them only while the pipeline is empty
module arm_forward_kinematics_5dof_top import afk_pkg::*; #(
	parameter int ANGLE_BITS = AFK_ANGLE_BITS,
	parameter int FRAC_BITS  = AFK_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	afk_in_if.sink                    in_ch,
	afk_out_if.source                 out_ch,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_idx,
	input  logic [FRAC_BITS+1:0]      cfg_data
);

	localparam int LB  = FRAC_BITS + 2;
	localparam int OB  = FRAC_BITS + 7;
	localparam int CW  = FRAC_BITS + 8;
	localparam int PW  = TRIG_W + CW;
	localparam int LAT = CORDIC_LAT + 8;

	localparam logic [LB-1:0] RST_QTR = LB'(1 << (FRAC_BITS - 2));
	localparam logic [LB-1:0] RST_L3  = LB'(((3 << FRAC_BITS) + 10) / 20);
	localparam logic [LB-1:0] RST_D   = LB'(((1 << FRAC_BITS) + 10) / 20);

	localparam logic signed [PW:0]   RND = (PW+1)'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [CW-1:0] HI  = (CW'(1) <<< (OB - 1)) - CW'(1);
	localparam logic signed [CW-1:0] LO  = -(CW'(1) <<< (OB - 1));

	function automatic logic signed [CW-1:0] rnd(input logic signed [PW:0] v);
		logic signed [PW:0] t;
		t = (v + RND) >>> TRIG_FRAC;
		return CW'(t);
	endfunction

	function automatic logic signed [OB-1:0] sat(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		t = v;
		if (v > HI) t = HI;
		if (v < LO) t = LO;
		return OB'(t);
	endfunction

	function automatic logic signed [CW-1:0] ext(input logic [LB-1:0] v);
		return signed'({{(CW-LB){1'b0}}, v});
	endfunction

	function automatic logic signed [PW-1:0] mul(input trig_t a,
		input logic signed [CW-1:0] b);
		return PW'(a) * PW'(b);
	endfunction

	function automatic logic signed [PW:0] sx(input logic signed [PW-1:0] v);
		return (PW+1)'(v);
	endfunction

	logic [LB-1:0] l0_q, l1_q, l2_q, l3_q, d1_q, d2_q;
	logic          en;
	logic [LAT-1:0] vld_q;

	trig_t c0, s0, c1, s1, c2, s2, c3, s3;
	logic signed [CW-1:0] l1e, l2e, l3e, d2e, y2e, l0e;

	logic signed [PW-1:0] pa_s1, pb_s1, pc_s1, pd_s1;
	trig_t c2_s1, s2_s1, c1_s1, s1_s1, c0_s1, s0_s1;
	logic signed [CW-1:0] x2_s2, z2_s2;
	trig_t c2_s2, s2_s2, c1_s2, s1_s2, c0_s2, s0_s2;
	logic signed [PW-1:0] pa_s3, pb_s3, pc_s3, pd_s3;
	trig_t c1_s3, s1_s3, c0_s3, s0_s3;
	logic signed [CW-1:0] x1_s4, z1_s4;
	trig_t c1_s4, s1_s4, c0_s4, s0_s4;
	logic signed [PW-1:0] pa_s5, pb_s5, pc_s5, pd_s5;
	trig_t c0_s5, s0_s5;
	logic signed [CW-1:0] x0_s6, z0_s6;
	trig_t c0_s6, s0_s6;
	logic signed [PW-1:0] pa_s7, pb_s7, pc_s7, pd_s7;
	logic signed [CW-1:0] zf_s7;
	logic signed [OB-1:0] x_s8, y_s8, z_s8;

	assign en           = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready  = en;
	assign out_ch.valid = vld_q[LAT-1];
	assign out_ch.pos_x = x_s8;
	assign out_ch.pos_y = y_s8;
	assign out_ch.pos_z = z_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l0_q <= RST_QTR;
			l1_q <= RST_QTR;
			l2_q <= RST_QTR;
			l3_q <= RST_L3;
			d1_q <= RST_D;
			d2_q <= RST_D;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BASE_HEIGHT:      l0_q <= cfg_data;
				REG_UPPER_ARM_LENGTH: l1_q <= cfg_data;
				REG_FOREARM_LENGTH:   l2_q <= cfg_data;
				REG_WRIST_LENGTH:     l3_q <= cfg_data;
				REG_SIDE_OFFSET:      d1_q <= cfg_data;
				REG_WRIST_DROP:       d2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	// wrist roll leaves the position unchanged
	afk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic0 (
		.clk(clk), .en(en), .ang(in_ch.base_angle), .cos_v(c0), .sin_v(s0));
	afk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic1 (
		.clk(clk), .en(en), .ang(in_ch.shoulder_angle), .cos_v(c1), .sin_v(s1));
	afk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic2 (
		.clk(clk), .en(en), .ang(in_ch.elbow_angle), .cos_v(c2), .sin_v(s2));
	afk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic3 (
		.clk(clk), .en(en), .ang(in_ch.wrist_pitch_angle), .cos_v(c3), .sin_v(s3));

	assign l0e = ext(l0_q);
	assign l1e = ext(l1_q);
	assign l2e = ext(l2_q);
	assign l3e = ext(l3_q);
	assign d2e = ext(d2_q);
	assign y2e = signed'({{(CW-LB-1){1'b0}}, d1_q, 1'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			// wrist pitch
			pa_s1 <= mul(c3, l3e);
			pb_s1 <= mul(s3, d2e);
			pc_s1 <= mul(s3, l3e);
			pd_s1 <= mul(c3, d2e);
			c2_s1 <= c2; s2_s1 <= s2; c1_s1 <= c1; s1_s1 <= s1;
			c0_s1 <= c0; s0_s1 <= s0;

			x2_s2 <= l2e + rnd(sx(pa_s1) + sx(pb_s1));
			z2_s2 <= rnd(sx(pd_s1) - sx(pc_s1));
			c2_s2 <= c2_s1; s2_s2 <= s2_s1; c1_s2 <= c1_s1; s1_s2 <= s1_s1;
			c0_s2 <= c0_s1; s0_s2 <= s0_s1;

			// elbow
			pa_s3 <= mul(c2_s2, x2_s2);
			pb_s3 <= mul(s2_s2, z2_s2);
			pc_s3 <= mul(s2_s2, x2_s2);
			pd_s3 <= mul(c2_s2, z2_s2);
			c1_s3 <= c1_s2; s1_s3 <= s1_s2; c0_s3 <= c0_s2; s0_s3 <= s0_s2;

			x1_s4 <= l1e + rnd(sx(pa_s3) + sx(pb_s3));
			z1_s4 <= rnd(sx(pd_s3) - sx(pc_s3));
			c1_s4 <= c1_s3; s1_s4 <= s1_s3; c0_s4 <= c0_s3; s0_s4 <= s0_s3;

			// shoulder
			pa_s5 <= mul(c1_s4, x1_s4);
			pb_s5 <= mul(s1_s4, z1_s4);
			pc_s5 <= mul(s1_s4, x1_s4);
			pd_s5 <= mul(c1_s4, z1_s4);
			c0_s5 <= c0_s4; s0_s5 <= s0_s4;

			x0_s6 <= rnd(sx(pa_s5) + sx(pb_s5));
			z0_s6 <= rnd(sx(pd_s5) - sx(pc_s5));
			c0_s6 <= c0_s5; s0_s6 <= s0_s5;

			// base
			pa_s7 <= mul(c0_s6, x0_s6);
			pb_s7 <= mul(s0_s6, y2e);
			pc_s7 <= mul(s0_s6, x0_s6);
			pd_s7 <= mul(c0_s6, y2e);
			zf_s7 <= l0e + z0_s6;

			x_s8 <= sat(rnd(sx(pa_s7) - sx(pb_s7)));
			y_s8 <= sat(rnd(sx(pc_s7) + sx(pd_s7)));
			z_s8 <= sat(zf_s7);
		end
	end

endmodule

>>> rtl/core/afk_cordic.sv
module afk_cordic import afk_pkg::*; #(
	parameter int ANGLE_BITS = AFK_ANGLE_BITS
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] ang,
	output trig_t                 cos_v,
	output trig_t                 sin_v
);

	logic [31:0] u;
	logic [31:0] uq;
	logic [31:0] uf;
	logic        flip;

	logic signed [CX_W-1:0] x_s [0:CORDIC_STEPS];
	logic signed [CX_W-1:0] y_s [0:CORDIC_STEPS];
	logic signed [CZ_W-1:0] z_s [0:CORDIC_STEPS];
	logic                   flip_s [0:CORDIC_STEPS];

	// fold second and third quadrant onto first and fourth
	assign u    = {ang, {(32-ANGLE_BITS){1'b0}}};
	assign uq   = u + 32'h4000_0000;
	assign flip = uq[31];
	assign uf   = flip ? (u + 32'h8000_0000) : u;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= signed'({uf[31], uf});
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CZ_W-1:0] at;
		assign at = signed'({1'b0, atan_val(i)});
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_v <= flip_s[CORDIC_STEPS] ? TRIG_W'(-x_s[CORDIC_STEPS])
				: TRIG_W'(x_s[CORDIC_STEPS]);
			sin_v <= flip_s[CORDIC_STEPS] ? TRIG_W'(-y_s[CORDIC_STEPS])
				: TRIG_W'(y_s[CORDIC_STEPS]);
		end
	end

endmodule

>>> tb/sv/tb_arm_forward_kinematics_5dof_top.sv
module tb_arm_forward_kinematics_5dof_top;
	import afk_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANG_W = 16;
	localparam int LEN_W = 18;
	localparam int POS_W = 23;
	localparam int N_JOINTS = 5;
	localparam int PIPE_LAT = 40;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_PHASES = 5;
	localparam int RAND_PER_PHASE = 110;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef enum logic {ROW_WRITE, ROW_REQ} row_kind_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} tip_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [LEN_W-1:0] data;
		logic [N_JOINTS-1:0][ANG_W-1:0] ang;
		bit known;
		tip_t tip;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [LEN_W-1:0] cfg_data;

	afk_in_if #(.ANGLE_BITS(ANG_W)) in_ch();
	afk_out_if #(.OUT_BITS(POS_W)) out_ch();

	arm_forward_kinematics_5dof_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	longint atan_lut [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
	};

	logic [LEN_W-1:0] link_reg [6];
	tip_t tip_q [$];
	row_t rows [$];
	int errors;
	int req_count;
	int res_count;
	int idle_cycles;
	bit no_stall;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void joint_trig(input logic [ANG_W-1:0] ang, output longint c,
			output longint s);
		logic [31:0] u;
		longint x, y, z, nx;
		bit flip;
		u = {ang, 16'h0};
		flip = u[31] ^ u[30];
		if (flip)
			u = u + 32'h8000_0000;
		z = longint'($signed(u));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - atan_lut[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + atan_lut[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint rot_mac(input longint p, input longint a, input longint q,
			input longint b);
		return (p * a + q * b + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
		longint hi, lo;
		hi = (longint'(1) << (POS_W - 1)) - 1;
		lo = -(longint'(1) << (POS_W - 1));
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v[POS_W-1:0];
	endfunction

	// wrist roll cannot move the tip, so joint 4 is never read
	function automatic tip_t tip_position(input logic [N_JOINTS-1:0][ANG_W-1:0] ang);
		longint c[4], s[4];
		longint l0, l1, l2, l3, d1, d2;
		longint x2, y2, z2, x1, z1, x0, z0;
		tip_t t;
		for (int j = 0; j < 4; j++)
			joint_trig(ang[j], c[j], s[j]);
		l0 = link_reg[REG_BASE_HEIGHT];
		l1 = link_reg[REG_UPPER_ARM_LENGTH];
		l2 = link_reg[REG_FOREARM_LENGTH];
		l3 = link_reg[REG_WRIST_LENGTH];
		d1 = link_reg[REG_SIDE_OFFSET];
		d2 = link_reg[REG_WRIST_DROP];
		x2 = l2 + rot_mac(c[3], l3, s[3], d2);
		y2 = d1 + d1;
		z2 = rot_mac(-s[3], l3, c[3], d2);
		x1 = l1 + rot_mac(c[2], x2, s[2], z2);
		z1 = rot_mac(-s[2], x2, c[2], z2);
		x0 = rot_mac(c[1], x1, s[1], z1);
		z0 = rot_mac(-s[1], x1, c[1], z1);
		t.x = clamp_pos(rot_mac(c[0], x0, -s[0], y2));
		t.y = clamp_pos(rot_mac(s[0], x0, c[0], y2));
		t.z = clamp_pos(l0 + z0);
		return t;
	endfunction

	task automatic report(input string what, input logic signed [POS_W-1:0] got,
			input logic signed [POS_W-1:0] want);
		$display("mismatch %s at result %0d: got %0d want %0d", what, res_count, got, want);
		errors++;
	endtask

	task automatic add_req(input logic [N_JOINTS-1:0][ANG_W-1:0] ang, input bit known,
			input tip_t tip);
		row_t r;
		r.kind = ROW_REQ;
		r.idx = '0;
		r.data = '0;
		r.ang = ang;
		r.known = known;
		r.tip = tip;
		rows.push_back(r);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
		row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		r.ang = '0;
		r.known = 0;
		r.tip = '0;
		rows.push_back(r);
	endtask

	// called with no request pending
	task automatic write_link(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
		while (tip_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < 6)
			link_reg[idx] = data;
	endtask

	task automatic send_req(input logic [N_JOINTS-1:0][ANG_W-1:0] ang, input bit known,
			input tip_t tip);
		int gap;
		gap = no_stall ? 0 : int'($urandom_range(0, 13));
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.wrist_roll_angle, in_ch.wrist_pitch_angle, in_ch.elbow_angle,
			in_ch.shoulder_angle, in_ch.base_angle} <= ang;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		tip_q.push_back(known ? tip : tip_position(ang));
		req_count++;
	endtask

	function automatic logic [ANG_W-1:0] pick_angle();
		logic [ANG_W-1:0] corner [8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h3FFF,
			16'h8000, 16'h7FFF, 16'hC000, 16'hBFFF};
		if ($urandom_range(0, 4) == 0)
			return corner[$urandom_range(0, 7)];
		return ANG_W'($urandom_range(0, 65535));
	endfunction

	// receiving side
	initial begin
		int stall;
		tip_t want;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_stall ? 0 : int'($urandom_range(0, 13));
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
			if (tip_q.size() == 0) begin
				$display("unexpected result %0d", res_count);
				errors++;
			end else begin
				want = tip_q.pop_front();
				if (out_ch.pos_x !== want.x)
					report("pos_x", out_ch.pos_x, want.x);
				if (out_ch.pos_y !== want.y)
					report("pos_y", out_ch.pos_y, want.y);
				if (out_ch.pos_z !== want.z)
					report("pos_z", out_ch.pos_z, want.z);
			end
			res_count++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [N_JOINTS-1:0][ANG_W-1:0] ang;
		logic [LEN_W-1:0] v;
		tip_t origin;
		int mode;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.base_angle = '0;
		in_ch.shoulder_angle = '0;
		in_ch.elbow_angle = '0;
		in_ch.wrist_pitch_angle = '0;
		in_ch.wrist_roll_angle = '0;
		errors = 0;
		req_count = 0;
		res_count = 0;
		idle_cycles = 0;
		no_stall = 0;
		origin = '0;
		link_reg = '{18'd16384, 18'd16384, 18'd16384, 18'd9830, 18'd3277, 18'd3277};

		// default links after reset
		add_req({5{16'h0000}}, 0, origin);
		add_req({5{16'hFFFF}}, 0, origin);
		add_req({5{16'h4000}}, 0, origin);
		add_req({5{16'h8000}}, 0, origin);
		add_req({5{16'hC000}}, 0, origin);
		add_req({5{16'h3FFF}}, 0, origin);
		add_req({5{16'hBFFF}}, 0, origin);
		add_req({16'h0000, 16'h1111, 16'h2222, 16'h3333, 16'h4444}, 0, origin);
		add_req({16'hFFFF, 16'h1111, 16'h2222, 16'h3333, 16'h4444}, 0, origin);
		add_req({16'h1234, 16'h1111, 16'h2222, 16'h3333, 16'h4444}, 0, origin);
		// zero links put the tip at the origin; spare indexes must not land anywhere
		for (int r = 0; r < 6; r++)
			add_write(CFG_IDX_W'(r), '0);
		add_write(REG_SPARE_6, LEN_MAX);
		add_write(REG_SPARE_7, LEN_MAX);
		add_req({5{16'h0000}}, 1, origin);
		add_req({5{16'hFFFF}}, 1, origin);
		add_req({5{16'hAAAA}}, 1, origin);
		add_req({5{16'h5555}}, 1, origin);
		add_req({16'h8000, 16'hC000, 16'h4000, 16'h8000, 16'h0001}, 1, origin);
		// longest links
		for (int r = 0; r < 6; r++)
			add_write(CFG_IDX_W'(r), LEN_MAX);
		add_req({5{16'h0000}}, 0, origin);
		add_req({5{16'h8000}}, 0, origin);
		add_req({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000}, 0, origin);
		add_req({16'h0000, 16'hC000, 16'hC000, 16'hC000, 16'h2000}, 0, origin);
		add_req({16'h7FFF, 16'h0000, 16'h4000, 16'h8000, 16'hE000}, 0, origin);
		add_req({16'h0001, 16'hFFFE, 16'h0001, 16'hFFFE, 16'h0001}, 0, origin);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				write_link(rows[i].idx, rows[i].data);
			end else begin
				send_req(rows[i].ang, rows[i].known, rows[i].tip);
			end
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			for (int r = 0; r < 6; r++) begin
				mode = $urandom_range(0, 3);
				if (p == 1)
					v = LEN_MAX;
				else if (p == 3)
					v = (r == 0) ? '0 : LEN_W'($urandom_range(0, 262143));
				else if (mode == 0)
					v = LEN_W'($urandom_range(0, 8192));
				else
					v = LEN_W'($urandom_range(0, 262143));
				write_link(CFG_IDX_W'(r), v);
			end
			write_link(CFG_IDX_W'($urandom_range(6, 7)), LEN_W'($urandom_range(0, 262143)));
			no_stall = (p == 2);
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				for (int j = 0; j < N_JOINTS; j++)
					ang[j] = pick_angle();
				send_req(ang, 0, origin);
			end
		end
		in_ch.valid <= 1'b0;
		no_stall = 0;

		while (tip_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 20) @(posedge clk);

		$display("%0d joint requests and %0d tip results over %0d link settings",
			req_count, res_count, RAND_PHASES + 3);
		$display("zero, default and longest links, turn corners, back-to-back and stalled");
		if (errors == 0 && tip_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
